### sv/aw_pkg.sv
// AdamW update engine: shared types, constants and float helper functions.
// Used by the float units and the top level of the engine; depends on nothing else.
package aw_pkg;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [31:0] FP_ONE    = 32'h3F80_0000;
    localparam logic [31:0] FP_EPS    = 32'h3586_37BD;  // 1.0e-6

    localparam logic [31:0] RST_FIRST_DECAY       = 32'h3F66_6666;
    localparam logic [31:0] RST_SECOND_DECAY      = 32'h3F7F_BE77;
    localparam logic [31:0] RST_FIRST_CORRECTION  = 32'h3F80_0000;
    localparam logic [31:0] RST_SECOND_CORRECTION = 32'h3F80_0000;
    localparam logic [31:0] RST_STEP_SIZE         = 32'h3A83_126F;
    localparam logic [31:0] RST_SHRINK_FACTOR     = 32'h3F80_0000;

    // root/quotient bits produced per pipeline stage
    localparam int STEPS_PER_STAGE = 4;
    localparam int ITER_STAGES     = 28 / STEPS_PER_STAGE;

    localparam int MUL_LAT  = 3;
    localparam int ADD_LAT  = 4;
    localparam int DIV_LAT  = ITER_STAGES + 2;
    localparam int SQRT_LAT = ITER_STAGES + 2;

    typedef enum logic [2:0] {
        REG_FIRST_DECAY       = 3'd0,
        REG_SECOND_DECAY      = 3'd1,
        REG_FIRST_CORRECTION  = 3'd2,
        REG_SECOND_CORRECTION = 3'd3,
        REG_STEP_SIZE         = 3'd4,
        REG_SHRINK_FACTOR     = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic sign;
        logic nan;
        logic inf;
        logic zero;
    } fp_spec_t;

    // value = mant / 2^23 * 2^exp, mant normalized unless zero
    typedef struct packed {
        logic               sign;
        logic               nan;
        logic               inf;
        logic               zero;
        logic signed [9:0]  exp;
        logic [23:0]        mant;
    } fp_unp_t;

    function automatic logic [4:0] lzc27(input logic [26:0] x);
        logic [4:0] cnt;
        cnt = 5'd27;
        for (int i = 0; i < 27; i++)
        begin
            if (x[i])
            begin
                cnt = 5'(26 - i);
            end
        end
        return cnt;
    endfunction

    function automatic fp_unp_t fp_unpack(input logic [31:0] x);
        fp_unp_t    u;
        logic [4:0] lz;
        u.sign = x[31];
        u.nan  = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
        u.inf  = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
        u.zero = (x[30:23] == 8'h00) && (x[22:0] == 23'd0);
        lz     = lzc27({1'b0, x[22:0], 3'b000});
        if (x[30:23] != 8'h00)
        begin
            u.mant = {1'b1, x[22:0]};
            u.exp  = $signed({2'b00, x[30:23]}) - 10'sd127;
        end
        else
        begin
            u.mant = {1'b0, x[22:0]} << lz;
            u.exp  = -10'sd126 - $signed({5'b00000, lz});
        end
        return u;
    endfunction

    // sig has its leading one at bit 26: value = sig / 2^26 * 2^e
    function automatic logic [31:0] fp_round(input logic sign, input logic signed [11:0] e,
                                             input logic [26:0] sig, input logic st);
        logic signed [11:0] be;
        logic signed [11:0] shw;
        logic [4:0]         sh;
        logic [26:0]        shifted;
        logic               lost;
        logic [30:0]        field;
        logic               g;
        logic               s;
        logic               inc;
        be      = e + 12'sd127;
        shw     = 12'sd1 - be;
        sh      = (shw > 12'sd27) ? 5'd27 : shw[4:0];
        shifted = sig >> sh;
        lost    = |(sig & ~(27'h7FF_FFFF << sh));
        if (be >= 12'sd1)
        begin
            field = {be[7:0], sig[25:3]};
            g     = sig[2];
            s     = (|sig[1:0]) | st;
        end
        else
        begin
            field = {8'h00, shifted[25:3]};
            g     = shifted[2];
            s     = (|shifted[1:0]) | lost | st;
        end
        inc = g & (s | field[0]);
        if (be >= 12'sd255)
        begin
            return {sign, 8'hFF, 23'd0};
        end
        return {sign, field + {30'd0, inc}};
    endfunction

    function automatic logic [31:0] fp_special(input fp_spec_t sp);
        if (sp.nan)
        begin
            return CANON_NAN;
        end
        if (sp.inf)
        begin
            return {sp.sign, 8'hFF, 23'd0};
        end
        return {sp.sign, 31'd0};
    endfunction

endpackage

### sv/aw_in_if.sv
// Input request channel of the AdamW engine: one weight element per request.
// Stand-alone interface; no package use.
interface aw_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] gradient;
    logic [31:0] first_moment;
    logic [31:0] second_moment;
    logic [31:0] weight;
    logic        last_element;

    modport source (output valid, gradient, first_moment, second_moment, weight, last_element,
                    input ready);
    modport sink (input valid, gradient, first_moment, second_moment, weight, last_element,
                  output ready);
endinterface

### sv/aw_out_if.sv
// Result channel of the AdamW engine: updated moments and weight.
// Stand-alone interface; no package use.
interface aw_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] new_first_moment;
    logic [31:0] new_second_moment;
    logic [31:0] new_weight;
    logic        last_out;

    modport source (output valid, new_first_moment, new_second_moment, new_weight, last_out,
                    input ready);
    modport sink (input valid, new_first_moment, new_second_moment, new_weight, last_out,
                  output ready);
endinterface

### sv/aw_fmul.sv
// Pipelined binary32 multiplier: unpack, 24x24 product, round.
// Depends on aw_pkg.
module aw_fmul
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] y
);

    aw_pkg::fp_unp_t    ua_reg;
    aw_pkg::fp_unp_t    ub_reg;
    logic [47:0]        prod_reg;
    logic signed [11:0] e_reg;
    aw_pkg::fp_spec_t   sp_reg;
    logic [31:0]        y_reg;

    aw_pkg::fp_spec_t   sp_next;
    logic [31:0]        y_next;

    always_comb
    begin
        sp_next.sign = ua_reg.sign ^ ub_reg.sign;
        sp_next.nan  = ua_reg.nan | ub_reg.nan | (ua_reg.inf & ub_reg.zero)
                     | (ua_reg.zero & ub_reg.inf);
        sp_next.inf  = ua_reg.inf | ub_reg.inf;
        sp_next.zero = ua_reg.zero | ub_reg.zero;
    end

    always_comb
    begin
        if (sp_reg.nan || sp_reg.inf || sp_reg.zero)
        begin
            y_next = aw_pkg::fp_special(sp_reg);
        end
        else if (prod_reg[47])
        begin
            y_next = aw_pkg::fp_round(sp_reg.sign, e_reg + 12'sd1, prod_reg[47:21],
                                      |prod_reg[20:0]);
        end
        else
        begin
            y_next = aw_pkg::fp_round(sp_reg.sign, e_reg, prod_reg[46:20], |prod_reg[19:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ua_reg   <= aw_pkg::fp_unpack(a);
            ub_reg   <= aw_pkg::fp_unpack(b);
            prod_reg <= ua_reg.mant * ub_reg.mant;
            e_reg    <= $signed({{2{ua_reg.exp[9]}}, ua_reg.exp})
                      + $signed({{2{ub_reg.exp[9]}}, ub_reg.exp});
            sp_reg   <= sp_next;
            y_reg    <= y_next;
        end
    end

    assign y = y_reg;

endmodule

### sv/aw_fadd.sv
// Pipelined binary32 adder: align, add, leading-zero count, normalize and round.
// Depends on aw_pkg.
module aw_fadd
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] y
);

    // stage 1: operands ordered by magnitude, smaller one aligned
    logic [31:0]      big;
    logic [31:0]      sml;
    logic [7:0]       eb;
    logic [7:0]       es;
    logic [7:0]       d;
    logic [4:0]       sh;
    logic [26:0]      sm27;
    logic [26:0]      shifted;
    logic             st;
    aw_pkg::fp_spec_t sp1_next;
    logic             nan_a;
    logic             nan_b;
    logic             inf_a;
    logic             inf_b;

    logic [7:0]       e1_reg;
    logic [26:0]      mbig_reg;
    logic [26:0]      msml_reg;
    logic             sub1_reg;
    logic             sbig1_reg;
    logic             zsign1_reg;
    aw_pkg::fp_spec_t sp1_reg;

    logic [27:0]      sum2_reg;
    logic [7:0]       e2_reg;
    logic             sbig2_reg;
    logic             zsign2_reg;
    aw_pkg::fp_spec_t sp2_reg;

    logic [27:0]      sum3_reg;
    logic [4:0]       lz3_reg;
    logic [7:0]       e3_reg;
    logic             sbig3_reg;
    logic             zsign3_reg;
    aw_pkg::fp_spec_t sp3_reg;

    logic [31:0]      y_reg;
    logic [31:0]      y_next;
    logic signed [11:0] e_base;

    always_comb
    begin
        if (b[30:0] > a[30:0])
        begin
            big = b;
            sml = a;
        end
        else
        begin
            big = a;
            sml = b;
        end
        eb      = (big[30:23] == 8'h00) ? 8'd1 : big[30:23];
        es      = (sml[30:23] == 8'h00) ? 8'd1 : sml[30:23];
        d       = eb - es;
        sh      = (d > 8'd27) ? 5'd27 : d[4:0];
        sm27    = {sml[30:23] != 8'h00, sml[22:0], 3'b000};
        shifted = sm27 >> sh;
        st      = |(sm27 & ~(27'h7FF_FFFF << sh));
        nan_a   = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        nan_b   = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        inf_a   = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        inf_b   = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        sp1_next.nan  = nan_a | nan_b | (inf_a & inf_b & (a[31] != b[31]));
        sp1_next.inf  = inf_a | inf_b;
        sp1_next.sign = inf_a ? a[31] : b[31];
        sp1_next.zero = 1'b0;
    end

    always_comb
    begin
        e_base = $signed({4'b0000, e3_reg}) - 12'sd127;
        if (sp3_reg.nan || sp3_reg.inf)
        begin
            y_next = aw_pkg::fp_special(sp3_reg);
        end
        else if (sum3_reg == 28'd0)
        begin
            y_next = {zsign3_reg, 31'd0};
        end
        else if (sum3_reg[27])
        begin
            y_next = aw_pkg::fp_round(sbig3_reg, e_base + 12'sd1, sum3_reg[27:1], sum3_reg[0]);
        end
        else
        begin
            y_next = aw_pkg::fp_round(sbig3_reg, e_base - $signed({7'd0, lz3_reg}),
                                      sum3_reg[26:0] << lz3_reg, 1'b0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_reg     <= eb;
            mbig_reg   <= {big[30:23] != 8'h00, big[22:0], 3'b000};
            msml_reg   <= {shifted[26:1], shifted[0] | st};
            sub1_reg   <= big[31] ^ sml[31];
            sbig1_reg  <= big[31];
            zsign1_reg <= a[31] & b[31];
            sp1_reg    <= sp1_next;

            sum2_reg   <= sub1_reg ? ({1'b0, mbig_reg} - {1'b0, msml_reg})
                                   : ({1'b0, mbig_reg} + {1'b0, msml_reg});
            e2_reg     <= e1_reg;
            sbig2_reg  <= sbig1_reg;
            zsign2_reg <= zsign1_reg;
            sp2_reg    <= sp1_reg;

            sum3_reg   <= sum2_reg;
            lz3_reg    <= aw_pkg::lzc27(sum2_reg[26:0]);
            e3_reg     <= e2_reg;
            sbig3_reg  <= sbig2_reg;
            zsign3_reg <= zsign2_reg;
            sp3_reg    <= sp2_reg;

            y_reg      <= y_next;
        end
    end

    assign y = y_reg;

endmodule

### sv/aw_fdiv.sv
// Pipelined binary32 divider: restoring digit recurrence, a few quotient bits per stage.
// Depends on aw_pkg.
module aw_fdiv
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] y
);

    typedef struct packed {
        logic [24:0]        rem;
        logic [27:0]        quo;
        logic [23:0]        dsr;
        logic signed [11:0] e;
        aw_pkg::fp_spec_t   spec;
    } div_st_t;

    function automatic div_st_t div_steps(input div_st_t s_in);
        div_st_t s;
        s = s_in;
        for (int i = 0; i < aw_pkg::STEPS_PER_STAGE; i++)
        begin
            if (s.rem >= {1'b0, s.dsr})
            begin
                s.rem = s.rem - {1'b0, s.dsr};
                s.quo = {s.quo[26:0], 1'b1};
            end
            else
            begin
                s.quo = {s.quo[26:0], 1'b0};
            end
            s.rem = {s.rem[23:0], 1'b0};
        end
        return s;
    endfunction

    aw_pkg::fp_unp_t ua_reg;
    aw_pkg::fp_unp_t ub_reg;
    div_st_t         it_reg [aw_pkg::ITER_STAGES];
    div_st_t         init;
    div_st_t         fin;
    logic [31:0]     y_reg;
    logic [31:0]     y_next;

    always_comb
    begin
        init.rem       = {1'b0, ua_reg.mant};
        init.quo       = 28'd0;
        init.dsr       = ub_reg.mant;
        init.e         = $signed({{2{ua_reg.exp[9]}}, ua_reg.exp})
                       - $signed({{2{ub_reg.exp[9]}}, ub_reg.exp});
        init.spec.sign = ua_reg.sign ^ ub_reg.sign;
        init.spec.nan  = ua_reg.nan | ub_reg.nan | (ua_reg.zero & ub_reg.zero)
                       | (ua_reg.inf & ub_reg.inf);
        init.spec.inf  = ua_reg.inf | ub_reg.zero;
        init.spec.zero = ua_reg.zero | ub_reg.inf;
    end

    always_comb
    begin
        fin = it_reg[aw_pkg::ITER_STAGES-1];
        if (fin.spec.nan || fin.spec.inf || fin.spec.zero)
        begin
            y_next = aw_pkg::fp_special(fin.spec);
        end
        else if (fin.quo[27])
        begin
            y_next = aw_pkg::fp_round(fin.spec.sign, fin.e, fin.quo[27:1],
                                      fin.quo[0] | (fin.rem != 25'd0));
        end
        else
        begin
            y_next = aw_pkg::fp_round(fin.spec.sign, fin.e - 12'sd1, fin.quo[26:0],
                                      fin.rem != 25'd0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ua_reg    <= aw_pkg::fp_unpack(a);
            ub_reg    <= aw_pkg::fp_unpack(b);
            it_reg[0] <= div_steps(init);
            for (int i = 1; i < aw_pkg::ITER_STAGES; i++)
            begin
                it_reg[i] <= div_steps(it_reg[i-1]);
            end
            y_reg     <= y_next;
        end
    end

    assign y = y_reg;

endmodule

### sv/aw_fsqrt.sv
// Pipelined binary32 square root: digit-by-digit integer root, a few bits per stage.
// Depends on aw_pkg.
module aw_fsqrt
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    output logic [31:0] y
);

    typedef struct packed {
        logic [29:0]        rem;
        logic [27:0]        root;
        logic [55:0]        rad;
        logic signed [11:0] e;
        aw_pkg::fp_spec_t   spec;
    } sqrt_st_t;

    function automatic sqrt_st_t sqrt_steps(input sqrt_st_t s_in);
        sqrt_st_t    s;
        logic [29:0] trial;
        s = s_in;
        for (int i = 0; i < aw_pkg::STEPS_PER_STAGE; i++)
        begin
            s.rem = {s.rem[27:0], s.rad[55:54]};
            s.rad = {s.rad[53:0], 2'b00};
            trial = {s.root, 2'b01};
            if (s.rem >= trial)
            begin
                s.rem  = s.rem - trial;
                s.root = {s.root[26:0], 1'b1};
            end
            else
            begin
                s.root = {s.root[26:0], 1'b0};
            end
        end
        return s;
    endfunction

    aw_pkg::fp_unp_t ua_reg;
    sqrt_st_t        it_reg [aw_pkg::ITER_STAGES];
    sqrt_st_t        init;
    sqrt_st_t        fin;
    logic [31:0]     y_reg;
    logic [31:0]     y_next;

    always_comb
    begin
        init.rem  = 30'd0;
        init.root = 28'd0;
        // odd exponent: one more doubling of the radicand
        init.rad  = ua_reg.exp[0] ? {ua_reg.mant, 32'd0} : {1'b0, ua_reg.mant, 31'd0};
        init.e    = $signed({{3{ua_reg.exp[9]}}, ua_reg.exp[9:1]});
        init.spec.sign = ua_reg.sign;
        init.spec.nan  = ua_reg.nan | (ua_reg.sign & ~ua_reg.zero);
        init.spec.inf  = ua_reg.inf;
        init.spec.zero = ua_reg.zero;
    end

    always_comb
    begin
        fin = it_reg[aw_pkg::ITER_STAGES-1];
        if (fin.spec.nan || fin.spec.inf || fin.spec.zero)
        begin
            y_next = aw_pkg::fp_special(fin.spec);
        end
        else
        begin
            y_next = aw_pkg::fp_round(1'b0, fin.e, fin.root[27:1],
                                      fin.root[0] | (fin.rem != 30'd0));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ua_reg    <= aw_pkg::fp_unpack(a);
            it_reg[0] <= sqrt_steps(init);
            for (int i = 1; i < aw_pkg::ITER_STAGES; i++)
            begin
                it_reg[i] <= sqrt_steps(it_reg[i-1]);
            end
            y_reg     <= y_next;
        end
    end

    assign y = y_reg;

endmodule

### sv/adamw_weight_update.sv
// AdamW weight update engine, binary32, one element per request.
// Throughput one request per cycle while no result is held waiting at the output.
// The whole pipeline advances together; it holds only while a result waits at the output.
// The longest segment is the sqrt/divide path (9 stages each, 4 root/quotient bits a stage).
// Reset clears all valid bits and loads the default coefficients; datapath is not reset.
// Depends on aw_pkg, aw_in_if, aw_out_if, aw_fmul, aw_fadd, aw_fdiv, aw_fsqrt.
module adamw_weight_update
(
    input  logic        clk,
    input  logic        rst_n,
    aw_in_if.sink       item,
    aw_out_if.source    result,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int T_P2    = aw_pkg::ADD_LAT;
    localparam int T_SUM1  = T_P2 + aw_pkg::MUL_LAT;
    localparam int T_C     = T_SUM1 + aw_pkg::ADD_LAT;
    localparam int T_SQ    = T_C + aw_pkg::MUL_LAT;
    localparam int T_EPS   = T_SQ + aw_pkg::SQRT_LAT;
    localparam int T_DIV   = T_EPS + aw_pkg::ADD_LAT;
    localparam int T_RATE  = T_DIV + aw_pkg::DIV_LAT;
    localparam int T_FIN   = T_RATE + aw_pkg::MUL_LAT;
    localparam int T_OUT   = T_FIN + aw_pkg::ADD_LAT;
    localparam int G_DLY   = T_P2;
    localparam int GG_DLY  = T_P2 - aw_pkg::MUL_LAT;
    localparam int P_DLY   = T_SUM1 - aw_pkg::MUL_LAT;
    localparam int MH_DLY  = T_DIV - T_SQ;
    localparam int WS_DLY  = T_FIN - aw_pkg::MUL_LAT;
    localparam int MV_DLY  = T_OUT - T_C;

    logic [31:0] first_decay_reg;
    logic [31:0] second_decay_reg;
    logic [31:0] first_correction_reg;
    logic [31:0] second_correction_reg;
    logic [31:0] step_size_reg;
    logic [31:0] shrink_factor_reg;

    logic [T_OUT-1:0] vld_reg;
    logic [T_OUT-1:0] vld_next;
    logic             en;

    logic [31:0] g_dly_reg  [G_DLY];
    logic [31:0] gg_dly_reg [GG_DLY];
    logic [31:0] p1_dly_reg [P_DLY];
    logic [31:0] p3_dly_reg [P_DLY];
    logic [31:0] mh_dly_reg [MH_DLY];
    logic [31:0] ws_dly_reg [WS_DLY];
    logic [31:0] nm_dly_reg [MV_DLY];
    logic [31:0] nv_dly_reg [MV_DLY];
    logic        last_dly_reg [T_OUT];

    logic [31:0] one_m_b1;
    logic [31:0] one_m_b2;
    logic [31:0] gg;
    logic [31:0] p1;
    logic [31:0] p2;
    logic [31:0] p3;
    logic [31:0] p4;
    logic [31:0] ws;
    logic [31:0] nm;
    logic [31:0] nv;
    logic [31:0] mh;
    logic [31:0] vh;
    logic [31:0] root;
    logic [31:0] den;
    logic [31:0] quo;
    logic [31:0] stp;
    logic [31:0] nw;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_decay_reg       <= aw_pkg::RST_FIRST_DECAY;
            second_decay_reg      <= aw_pkg::RST_SECOND_DECAY;
            first_correction_reg  <= aw_pkg::RST_FIRST_CORRECTION;
            second_correction_reg <= aw_pkg::RST_SECOND_CORRECTION;
            step_size_reg         <= aw_pkg::RST_STEP_SIZE;
            shrink_factor_reg     <= aw_pkg::RST_SHRINK_FACTOR;
        end
        else if (cfg_we)
        begin
            case (aw_pkg::cfg_reg_t'(cfg_index))
                aw_pkg::REG_FIRST_DECAY:       first_decay_reg       <= cfg_data;
                aw_pkg::REG_SECOND_DECAY:      second_decay_reg      <= cfg_data;
                aw_pkg::REG_FIRST_CORRECTION:  first_correction_reg  <= cfg_data;
                aw_pkg::REG_SECOND_CORRECTION: second_correction_reg <= cfg_data;
                aw_pkg::REG_STEP_SIZE:         step_size_reg         <= cfg_data;
                aw_pkg::REG_SHRINK_FACTOR:     shrink_factor_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control
    assign en       = !result.valid || result.ready;
    assign vld_next = {vld_reg[T_OUT-2:0], item.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    assign item.ready = en;

    // side paths matching the float unit latencies
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_dly_reg[0]    <= item.gradient;
            gg_dly_reg[0]   <= gg;
            p1_dly_reg[0]   <= p1;
            p3_dly_reg[0]   <= p3;
            mh_dly_reg[0]   <= mh;
            ws_dly_reg[0]   <= ws;
            nm_dly_reg[0]   <= nm;
            nv_dly_reg[0]   <= nv;
            last_dly_reg[0] <= item.last_element;
            for (int i = 1; i < G_DLY; i++)
            begin
                g_dly_reg[i] <= g_dly_reg[i-1];
            end
            for (int i = 1; i < GG_DLY; i++)
            begin
                gg_dly_reg[i] <= gg_dly_reg[i-1];
            end
            for (int i = 1; i < P_DLY; i++)
            begin
                p1_dly_reg[i] <= p1_dly_reg[i-1];
                p3_dly_reg[i] <= p3_dly_reg[i-1];
            end
            for (int i = 1; i < MH_DLY; i++)
            begin
                mh_dly_reg[i] <= mh_dly_reg[i-1];
            end
            for (int i = 1; i < WS_DLY; i++)
            begin
                ws_dly_reg[i] <= ws_dly_reg[i-1];
            end
            for (int i = 1; i < MV_DLY; i++)
            begin
                nm_dly_reg[i] <= nm_dly_reg[i-1];
                nv_dly_reg[i] <= nv_dly_reg[i-1];
            end
            for (int i = 1; i < T_OUT; i++)
            begin
                last_dly_reg[i] <= last_dly_reg[i-1];
            end
        end
    end

    // moments
    aw_fadd u_one_m_b1 (.clk(clk), .en(en), .a(aw_pkg::FP_ONE),
                        .b({~first_decay_reg[31], first_decay_reg[30:0]}), .y(one_m_b1));
    aw_fadd u_one_m_b2 (.clk(clk), .en(en), .a(aw_pkg::FP_ONE),
                        .b({~second_decay_reg[31], second_decay_reg[30:0]}), .y(one_m_b2));
    aw_fmul u_gg (.clk(clk), .en(en), .a(item.gradient), .b(item.gradient), .y(gg));
    aw_fmul u_p1 (.clk(clk), .en(en), .a(first_decay_reg), .b(item.first_moment), .y(p1));
    aw_fmul u_p3 (.clk(clk), .en(en), .a(second_decay_reg), .b(item.second_moment), .y(p3));
    aw_fmul u_ws (.clk(clk), .en(en), .a(item.weight), .b(shrink_factor_reg), .y(ws));
    aw_fmul u_p2 (.clk(clk), .en(en), .a(one_m_b1), .b(g_dly_reg[G_DLY-1]), .y(p2));
    aw_fmul u_p4 (.clk(clk), .en(en), .a(one_m_b2), .b(gg_dly_reg[GG_DLY-1]), .y(p4));
    aw_fadd u_nm (.clk(clk), .en(en), .a(p1_dly_reg[P_DLY-1]), .b(p2), .y(nm));
    aw_fadd u_nv (.clk(clk), .en(en), .a(p3_dly_reg[P_DLY-1]), .b(p4), .y(nv));

    // bias-corrected step
    aw_fmul  u_mh (.clk(clk), .en(en), .a(nm), .b(first_correction_reg), .y(mh));
    aw_fmul  u_vh (.clk(clk), .en(en), .a(nv), .b(second_correction_reg), .y(vh));
    aw_fsqrt u_sq (.clk(clk), .en(en), .a(vh), .y(root));
    aw_fadd  u_den (.clk(clk), .en(en), .a(root), .b(aw_pkg::FP_EPS), .y(den));
    aw_fdiv  u_div (.clk(clk), .en(en), .a(mh_dly_reg[MH_DLY-1]), .b(den), .y(quo));
    aw_fmul  u_stp (.clk(clk), .en(en), .a(step_size_reg), .b(quo), .y(stp));
    aw_fadd  u_nw (.clk(clk), .en(en), .a(ws_dly_reg[WS_DLY-1]), .b(stp), .y(nw));

    assign result.valid             = vld_reg[T_OUT-1];
    assign result.new_first_moment  = nm_dly_reg[MV_DLY-1];
    assign result.new_second_moment = nv_dly_reg[MV_DLY-1];
    assign result.new_weight        = nw;
    assign result.last_out          = last_dly_reg[T_OUT-1];

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("valid chain moved while output stalled");

    a_weight_nan_canon: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.new_weight[30:23] == 8'hFF && result.new_weight[22:0] != 23'd0
        |-> result.new_weight == aw_pkg::CANON_NAN)
        else $error("non-canonical NaN on new_weight");

    a_moment_nan_canon: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.new_second_moment[30:23] == 8'hFF
        && result.new_second_moment[22:0] != 23'd0
        |-> result.new_second_moment == aw_pkg::CANON_NAN)
        else $error("non-canonical NaN on new_second_moment");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index == aw_pkg::REG_STEP_SIZE |=> step_size_reg == $past(cfg_data))
        else $error("step_size write lost");

endmodule

### bench/tb_adamw_weight_update.sv
// Self-checking adamw_weight_update bench: directed and random requests, random stalls on
// both channels, every result checked bit for bit against an integer binary32 predictor.
// Depends on aw_pkg, aw_in_if, aw_out_if and the engine RTL.
module tb_adamw_weight_update;
    import aw_pkg::*;

    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;
    localparam int         STALL_LIMIT = 4000;
    localparam int         DRAIN_WAIT  = 60;

    typedef struct packed {
        logic [31:0] g;
        logic [31:0] m;
        logic [31:0] v;
        logic [31:0] w;
        logic        last;
    } elem_t;

    typedef struct packed {
        logic [31:0] nm;
        logic [31:0] nv;
        logic [31:0] nw;
        logic        last;
    } upd_t;

    typedef struct {
        logic        s;
        logic        nan;
        logic        inf;
        logic        zero;
        logic [23:0] m;
        int          e;
    } fnum_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    aw_in_if  in_ch ();
    aw_out_if out_ch ();

    adamw_weight_update u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (in_ch),
        .result    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [31:0] coef [6];
    elem_t       pend_q [$];
    upd_t        upd_q [$];
    int          fails;
    int          gap_in;
    int          gap_out;
    int          quiet_in;
    int          quiet_out;
    int          stall_cnt;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ---------------- binary32 arithmetic on bit patterns ----------------

    function automatic fnum_t fp_split(input logic [31:0] x);
        fnum_t f;
        f.s    = x[31];
        f.nan  = (x[30:23] == 8'hFF) && (x[22:0] != 0);
        f.inf  = (x[30:23] == 8'hFF) && (x[22:0] == 0);
        f.zero = (x[30:0] == 0);
        if (x[30:23] == 8'h00)
        begin
            f.m = {1'b0, x[22:0]};
            f.e = -149;
        end
        else
        begin
            f.m = {1'b1, x[22:0]};
            f.e = int'(x[30:23]) - 150;
        end
        return f;
    endfunction

    // value = mag * 2^e, st flags nonzero bits below mag
    function automatic logic [31:0] fp_pack(input logic sgn, input logic [319:0] mag,
                                            input int e, input logic st);
        int           p;
        int           q;
        int           drop;
        logic [319:0] kept;
        logic [319:0] low;
        logic         g;
        logic         s;
        if (mag == 0)
        begin
            return {sgn, 31'd0};
        end
        p = 0;
        for (int i = 0; i < 320; i++)
        begin
            if (mag[i])
            begin
                p = i;
            end
        end
        q = e + p - 23;
        if (q < -149)
        begin
            q = -149;
        end
        drop = q - e;
        if (drop > 0)
        begin
            kept = mag >> drop;
            g    = mag[drop-1];
            low  = mag & ((320'd1 << (drop - 1)) - 320'd1);
            s    = (low != 0) | st;
        end
        else
        begin
            kept = mag << (-drop);
            g    = 1'b0;
            s    = st;
        end
        if (g && (s || kept[0]))
        begin
            kept = kept + 320'd1;
        end
        if (kept[24])
        begin
            kept = kept >> 1;
            q    = q + 1;
        end
        if (!kept[23])
        begin
            return {sgn, 8'h00, kept[22:0]};
        end
        if (q + 150 >= 255)
        begin
            return {sgn, 8'hFF, 23'd0};
        end
        return {sgn, 8'(q + 150), kept[22:0]};
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] x, input logic [31:0] y);
        fnum_t a;
        fnum_t b;
        a = fp_split(x);
        b = fp_split(y);
        if (a.nan || b.nan || (a.inf && b.zero) || (a.zero && b.inf))
        begin
            return CANON_NAN;
        end
        if (a.inf || b.inf)
        begin
            return {a.s ^ b.s, 8'hFF, 23'd0};
        end
        return fp_pack(a.s ^ b.s, 320'(a.m) * 320'(b.m), a.e + b.e, 1'b0);
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] x, input logic [31:0] y);
        fnum_t        a;
        fnum_t        b;
        logic [319:0] ma;
        logic [319:0] mb;
        logic [319:0] sum;
        logic         sgn;
        a = fp_split(x);
        b = fp_split(y);
        if (a.nan || b.nan || (a.inf && b.inf && (a.s != b.s)))
        begin
            return CANON_NAN;
        end
        if (a.inf)
        begin
            return {a.s, 8'hFF, 23'd0};
        end
        if (b.inf)
        begin
            return {b.s, 8'hFF, 23'd0};
        end
        // exact alignment on a fixed 2^-149 grid
        ma = 320'(a.m) << (a.e + 149);
        mb = 320'(b.m) << (b.e + 149);
        if (a.s == b.s)
        begin
            sum = ma + mb;
            sgn = a.s;
        end
        else if (ma >= mb)
        begin
            sum = ma - mb;
            sgn = a.s;
        end
        else
        begin
            sum = mb - ma;
            sgn = b.s;
        end
        if (sum == 0)
        begin
            sgn = a.s & b.s;
        end
        return fp_pack(sgn, sum, -149, 1'b0);
    endfunction

    function automatic logic [31:0] fp_div(input logic [31:0] x, input logic [31:0] y);
        fnum_t        a;
        fnum_t        b;
        logic [319:0] num;
        logic         sgn;
        a   = fp_split(x);
        b   = fp_split(y);
        sgn = a.s ^ b.s;
        if (a.nan || b.nan || (a.inf && b.inf) || (a.zero && b.zero))
        begin
            return CANON_NAN;
        end
        if (a.inf || b.zero)
        begin
            return {sgn, 8'hFF, 23'd0};
        end
        if (b.inf || a.zero)
        begin
            return {sgn, 31'd0};
        end
        num = 320'(a.m) << 60;
        return fp_pack(sgn, num / 320'(b.m), a.e - b.e - 60, (num % 320'(b.m)) != 0);
    endfunction

    function automatic logic [31:0] fp_sqrt(input logic [31:0] x);
        fnum_t        a;
        int           sh;
        int           e2;
        logic [127:0] n;
        logic [127:0] rem;
        logic [127:0] res;
        logic [127:0] bt;
        a = fp_split(x);
        if (a.nan)
        begin
            return CANON_NAN;
        end
        if (a.zero)
        begin
            return x;
        end
        if (a.s)
        begin
            return CANON_NAN;
        end
        if (a.inf)
        begin
            return x;
        end
        sh  = (a.e & 1) ? 61 : 60;
        e2  = a.e - sh;
        n   = 128'(a.m) << sh;
        rem = n;
        res = 0;
        bt  = 128'd1 << 126;
        while (bt > rem)
        begin
            bt = bt >> 2;
        end
        while (bt != 0)
        begin
            if (rem >= res + bt)
            begin
                rem = rem - (res + bt);
                res = (res >> 1) + bt;
            end
            else
            begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return fp_pack(1'b0, 320'(res), e2 / 2, rem != 0);
    endfunction

    function automatic upd_t predict_update(input elem_t x);
        upd_t        r;
        logic [31:0] mh;
        logic [31:0] vh;
        logic [31:0] den;
        logic [31:0] stp;
        logic [31:0] one_m1;
        logic [31:0] one_m2;
        one_m1 = fp_add(FP_ONE, {~coef[REG_FIRST_DECAY][31], coef[REG_FIRST_DECAY][30:0]});
        one_m2 = fp_add(FP_ONE, {~coef[REG_SECOND_DECAY][31], coef[REG_SECOND_DECAY][30:0]});
        r.nm = fp_add(fp_mul(coef[REG_FIRST_DECAY], x.m), fp_mul(one_m1, x.g));
        r.nv = fp_add(fp_mul(coef[REG_SECOND_DECAY], x.v), fp_mul(one_m2, fp_mul(x.g, x.g)));
        mh   = fp_mul(r.nm, coef[REG_FIRST_CORRECTION]);
        vh   = fp_mul(r.nv, coef[REG_SECOND_CORRECTION]);
        den  = fp_add(fp_sqrt(vh), FP_EPS);
        stp  = fp_mul(coef[REG_STEP_SIZE], fp_div(mh, den));
        r.nw = fp_add(fp_mul(x.w, coef[REG_SHRINK_FACTOR]), stp);
        r.last = x.last;
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic int idle_len(inout int quiet);
        int r;
        if (quiet > 0)
        begin
            quiet = quiet - 1;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            quiet = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50)
        begin
            return 0;
        end
        if (r < 82)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 96)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] rand_fp(input int lo, input int hi, input bit pos);
        int          r;
        logic        sgn;
        logic [22:0] frac;
        r    = $urandom_range(0, 19);
        sgn  = pos ? ($urandom_range(0, 15) == 0) : 1'($urandom);
        frac = 23'($urandom);
        case (r)
            0: return {sgn, 31'd0};
            1: return {sgn, 8'hFF, 23'd0};
            2: return {sgn, 8'hFF, frac | 23'd1};
            3: return {sgn, 8'h00, frac};
            4: return {sgn, 8'hFE, 23'h7F_FFFF};
            5: return {sgn, 8'h7F, 23'd0};
            6, 7: return $urandom();
            default: return {sgn, 8'($urandom_range(lo, hi)), frac};
        endcase
    endfunction

    task automatic queue_random(input int n);
        elem_t x;
        for (int i = 0; i < n; i++)
        begin
            x.g    = rand_fp(105, 132, 1'b0);
            x.m    = rand_fp(105, 132, 1'b0);
            x.v    = rand_fp(95, 130, 1'b1);
            x.w    = rand_fp(115, 130, 1'b0);
            x.last = ($urandom_range(0, 15) == 0);
            pend_q.push_back(x);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx < REG_SPARE_A)
        begin
            coef[idx] = val;
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(input logic [31:0] b1, input logic [31:0] b2,
                             input logic [31:0] c1, input logic [31:0] c2,
                             input logic [31:0] rate, input logic [31:0] shr);
        write_reg(REG_FIRST_DECAY, b1);
        write_reg(REG_SECOND_DECAY, b2);
        write_reg(REG_FIRST_CORRECTION, c1);
        write_reg(REG_SECOND_CORRECTION, c2);
        write_reg(REG_STEP_SIZE, rate);
        write_reg(REG_SHRINK_FACTOR, shr);
    endtask

    task automatic write_typical();
        write_all({1'b0, 8'd126, 23'($urandom)}, {1'b0, 8'd126, 7'h7F, 16'($urandom)},
                  {1'b0, 8'($urandom_range(127, 130)), 23'($urandom)},
                  {1'b0, 8'($urandom_range(127, 133)), 23'($urandom)},
                  {1'b0, 8'($urandom_range(105, 122)), 23'($urandom)},
                  {1'b0, 8'd126, 8'hFF, 15'($urandom)});
    endtask

    task automatic wait_idle();
        do
        begin
            @(posedge clk);
        end
        while (pend_q.size() != 0 || in_ch.valid || upd_q.size() != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // ---------------- request driver ----------------

    always @(posedge clk or negedge rst_n)
    begin
        elem_t nx;
        elem_t cur;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            gap_in = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                cur = {in_ch.gradient, in_ch.first_moment, in_ch.second_moment,
                       in_ch.weight, in_ch.last_element};
                upd_q.push_back(predict_update(cur));
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (gap_in > 0)
                begin
                    gap_in = gap_in - 1;
                    in_ch.valid <= 1'b0;
                end
                else if (pend_q.size() != 0)
                begin
                    nx = pend_q.pop_front();
                    in_ch.valid         <= 1'b1;
                    in_ch.gradient      <= nx.g;
                    in_ch.first_moment  <= nx.m;
                    in_ch.second_moment <= nx.v;
                    in_ch.weight        <= nx.w;
                    in_ch.last_element  <= nx.last;
                    gap_in = idle_len(quiet_in);
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- result monitor ----------------

    always @(posedge clk or negedge rst_n)
    begin
        upd_t want;
        upd_t got;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            gap_out = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = {out_ch.new_first_moment, out_ch.new_second_moment,
                       out_ch.new_weight, out_ch.last_out};
                if (upd_q.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                    begin
                        $display("unexpected result m=%h v=%h w=%h last=%b",
                                 got.nm, got.nv, got.nw, got.last);
                    end
                end
                else
                begin
                    want = upd_q.pop_front();
                    if (got != want)
                    begin
                        fails++;
                        if (fails <= 10)
                        begin
                            $display("mismatch exp m=%h v=%h w=%h last=%b",
                                     want.nm, want.nv, want.nw, want.last);
                            $display("         got m=%h v=%h w=%h last=%b",
                                     got.nm, got.nv, got.nw, got.last);
                        end
                    end
                end
            end
            if (gap_out > 0)
            begin
                gap_out = gap_out - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                gap_out = idle_len(quiet_out);
            end
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            begin
                stall_cnt = 0;
            end
            else
            begin
                stall_cnt = stall_cnt + 1;
            end
            if (stall_cnt >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ---------------- test sequence ----------------

    initial
    begin
        clk                  = 1'b0;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = REG_FIRST_DECAY;
        cfg_data             = 32'd0;
        in_ch.valid          = 1'b0;
        in_ch.gradient       = 32'd0;
        in_ch.first_moment   = 32'd0;
        in_ch.second_moment  = 32'd0;
        in_ch.weight         = 32'd0;
        in_ch.last_element   = 1'b0;
        out_ch.ready         = 1'b0;
        fails                = 0;
        stall_cnt            = 0;
        quiet_in             = 0;
        quiet_out            = 0;
        coef[REG_FIRST_DECAY]       = RST_FIRST_DECAY;
        coef[REG_SECOND_DECAY]      = RST_SECOND_DECAY;
        coef[REG_FIRST_CORRECTION]  = RST_FIRST_CORRECTION;
        coef[REG_SECOND_CORRECTION] = RST_SECOND_CORRECTION;
        coef[REG_STEP_SIZE]         = RST_STEP_SIZE;
        coef[REG_SHRINK_FACTOR]     = RST_SHRINK_FACTOR;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed corners at the reset coefficients
        pend_q.push_back({32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0});
        pend_q.push_back({32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1});
        pend_q.push_back({32'h3F80_0000, 32'h0000_0000, 32'h0000_0000, 32'h3F80_0000, 1'b0});
        pend_q.push_back({32'hBF80_0000, 32'h3F00_0000, 32'h3E80_0000, 32'hC000_0000, 1'b0});
        pend_q.push_back({32'h7F80_0000, 32'h3F00_0000, 32'h3E80_0000, 32'h3F80_0000, 1'b0});
        pend_q.push_back({32'hFF80_0000, 32'h3F00_0000, 32'h7F80_0000, 32'h3F80_0000, 1'b0});
        pend_q.push_back({32'h7FC0_0001, 32'h3F00_0000, 32'h3E80_0000, 32'h3F80_0000, 1'b0});
        pend_q.push_back({32'h3F00_0000, 32'hFFFF_FFFF, 32'h3E80_0000, 32'h3F80_0000, 1'b0});
        pend_q.push_back({32'h3D00_0000, 32'h3C00_0000, 32'hBF80_0000, 32'h3F80_0000, 1'b0});
        pend_q.push_back({32'h0000_0000, 32'h3C00_0000, 32'h8000_0000, 32'h3F80_0000, 1'b0});
        pend_q.push_back({32'h0000_0001, 32'h007F_FFFF, 32'h0000_0001, 32'h8000_0001, 1'b0});
        pend_q.push_back({32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b0});
        pend_q.push_back({32'hFF7F_FFFF, 32'h7F7F_FFFF, 32'h0000_0000, 32'hFF7F_FFFF, 1'b0});
        pend_q.push_back({32'h3A00_0000, 32'h3A80_0000, 32'h3400_0000, 32'h7F80_0000, 1'b1});
        pend_q.push_back({32'h0080_0000, 32'h0000_0000, 32'h0000_0000, 32'h3F80_0000, 1'b0});
        pend_q.push_back({32'h0000_0000, 32'hFE00_0000, 32'h0000_0010, 32'h3F80_0000, 1'b0});
        pend_q.push_back({32'h3A00_0000, 32'h3980_0000, 32'h3300_0000, 32'hBE00_0000, 1'b1});
        pend_q.push_back({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1});
        pend_q.push_back({32'h5F00_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0});
        pend_q.push_back({32'h1F00_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0});
        queue_random(150);
        wait_idle();

        write_typical();
        queue_random(150);
        wait_idle();

        write_all(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                  32'h0000_0000, 32'h0000_0000);
        queue_random(120);
        wait_idle();

        write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_random(80);
        wait_idle();

        // unit decays, huge and -1 corrections, minimum denormal rate, -0 shrink
        write_all(FP_ONE, FP_ONE, 32'h7F7F_FFFF, 32'hBF80_0000, 32'h0000_0001, 32'h8000_0000);
        queue_random(120);
        wait_idle();

        write_all($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
        queue_random(150);
        wait_idle();

        // writes to unmapped indexes must leave the coefficients alone
        write_typical();
        write_reg(REG_SPARE_A, $urandom());
        write_reg(REG_SPARE_B, $urandom());
        queue_random(200);
        wait_idle();

        write_all(RST_FIRST_DECAY, RST_SECOND_DECAY, RST_FIRST_CORRECTION,
                  RST_SECOND_CORRECTION, RST_STEP_SIZE, RST_SHRINK_FACTOR);
        queue_random(160);
        wait_idle();

        if (fails == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
